/* hw/rtl/pdr_pkg.sv */
// shared types and constants for the pi duty regulator with capture
// no dependencies; imported by every module of the block
package pdr_pkg;

	localparam int WAVE_LENGTH      = 1000;
	localparam int CAPTURE_POINTS   = 200;
	localparam int DECIMATION_RATIO = 10;

	localparam int WAVE_W  = $clog2(WAVE_LENGTH);
	localparam int DEC_W   = $clog2(DECIMATION_RATIO + 1);
	localparam int WAVE_HALF = WAVE_LENGTH / 2;

	localparam int SAMPLE_W   = 10;
	localparam int GAIN_W     = 16;
	localparam int PERIOD_W   = 16;
	localparam int DUTY_W     = 7;
	localparam int INDEX_W    = 8;
	localparam int ERR_W      = SAMPLE_W + 1;
	localparam int INTEG_W    = 24;
	localparam int PROD_P_W   = GAIN_W + ERR_W;
	localparam int PROD_I_W   = GAIN_W + INTEG_W;
	localparam int ACC_W      = PROD_I_W + 1;
	localparam int CMP_PROD_W = DUTY_W + PERIOD_W;

	localparam int DUTY_OFFSET = 50;
	localparam int DUTY_MAX    = 100;

	// floor(m / 100) as (m * RECIP_C) >> RECIP_SH, exact for m < 2^23
	localparam int RECIP_SH = 30;
	localparam longint RECIP_C = ((64'd1 << RECIP_SH) + 64'd99) / 64'd100;
	localparam int RECIP_W  = 24;
	localparam int SCALE_W  = CMP_PROD_W + RECIP_W;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P     = 3'd0,
		REG_GAIN_I     = 3'd1,
		REG_REF_HIGH   = 3'd2,
		REG_REF_LOW    = 3'd3,
		REG_PWM_PERIOD = 3'd4
	} reg_idx_t;

	localparam logic [SAMPLE_W-1:0] REF_HIGH_RST   = 10'd800;
	localparam logic [SAMPLE_W-1:0] REF_LOW_RST    = 10'd200;
	localparam logic [PERIOD_W-1:0] PWM_PERIOD_RST = 16'd3999;

	typedef struct packed {
		logic signed [GAIN_W-1:0]   gain_p;
		logic signed [GAIN_W-1:0]   gain_i;
		logic        [SAMPLE_W-1:0] ref_high;
		logic        [SAMPLE_W-1:0] ref_low;
		logic        [PERIOD_W-1:0] pwm_period;
	} cfg_t;

	typedef struct packed {
		logic                valid;
		logic [SAMPLE_W-1:0] measure;
		logic [SAMPLE_W-1:0] reference;
		logic [INDEX_W-1:0]  index;
		logic                done;
	} cap_t;

	typedef struct packed {
		logic signed [ERR_W-1:0]   err;
		logic signed [INTEG_W-1:0] integ;
		cap_t                      cap;
	} tick_t;

endpackage

/* hw/rtl/pdr_in_if.sv */
// input channel of the regulator: action and converter sample
// no dependencies
interface pdr_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [9:0] adc_sample;

	modport source (output valid, output action, output adc_sample, input ready);
	modport sink (input valid, input action, input adc_sample, output ready);
endinterface

/* hw/rtl/pdr_out_if.sv */
// result channel of the regulator: compare value, duty and capture point
// no dependencies
interface pdr_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] pwm_compare;
	logic [6:0]  duty_percent;
	logic        capture_valid;
	logic [9:0]  captured_measure;
	logic [9:0]  captured_reference;
	logic [7:0]  capture_index;
	logic        capture_done;

	modport source (output valid, output pwm_compare, output duty_percent,
		output capture_valid, output captured_measure, output captured_reference,
		output capture_index, output capture_done, input ready);
	modport sink (input valid, input pwm_compare, input duty_percent,
		input capture_valid, input captured_measure, input captured_reference,
		input capture_index, input capture_done, output ready);
endinterface

/* hw/rtl/pi_duty_regulator_with_capture.sv */
// pi duty regulator with decimated capture: top level, joins config, front and pipe
// depends on pdr_pkg, pdr_in_if, pdr_out_if, pdr_cfg, pdr_front, pdr_pipe
// tick beats pass registers s1, s2, s3, s4, s5 to the result; arm beats give none
// one beat per cycle unless result.ready stalls; the integral updates in each tick
// reset: arst_n clears all control state and loads register defaults at once
module pi_duty_regulator_with_capture (
	input  logic                           clk,
	input  logic                           arst_n,
	pdr_in_if.sink                         item,
	pdr_out_if.source                      result,
	input  logic                           cfg_wr_en,
	input  logic [pdr_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [pdr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import pdr_pkg::*;

	cfg_t  cfg;
	tick_t tick;
	logic  tick_valid;
	logic  take;

	pdr_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.idx    (cfg_idx),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	pdr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item       (item),
		.tick_valid (tick_valid),
		.tick       (tick),
		.take       (take)
	);

	pdr_pipe u_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.tick_valid (tick_valid),
		.tick       (tick),
		.take       (take),
		.result     (result)
	);
endmodule

/* hw/rtl/pdr_cfg.sv */
// configuration register file: gains, reference levels, pwm period
// depends on pdr_pkg
module pdr_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [pdr_pkg::CFG_IDX_W-1:0]  idx,
	input  logic [pdr_pkg::CFG_DATA_W-1:0] wdata,
	output pdr_pkg::cfg_t                  cfg
);
	import pdr_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p     <= '0;
			cfg_q.gain_i     <= '0;
			cfg_q.ref_high   <= REF_HIGH_RST;
			cfg_q.ref_low    <= REF_LOW_RST;
			cfg_q.pwm_period <= PWM_PERIOD_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_GAIN_P:     cfg_q.gain_p     <= $signed(wdata[GAIN_W-1:0]);
				REG_GAIN_I:     cfg_q.gain_i     <= $signed(wdata[GAIN_W-1:0]);
				REG_REF_HIGH:   cfg_q.ref_high   <= wdata[SAMPLE_W-1:0];
				REG_REF_LOW:    cfg_q.ref_low    <= wdata[SAMPLE_W-1:0];
				REG_PWM_PERIOD: cfg_q.pwm_period <= wdata[PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

/* hw/rtl/pdr_front.sv */
// input stage: reference wave, saturating integral and capture sequencing
// depends on pdr_pkg and pdr_in_if
module pdr_front (
	input  logic          clk,
	input  logic          arst_n,
	input  pdr_pkg::cfg_t cfg,
	pdr_in_if.sink        item,
	output logic          tick_valid,
	output pdr_pkg::tick_t tick,
	input  logic          take
);
	import pdr_pkg::*;

	logic [WAVE_W-1:0]  wave_pos_q;
	logic [INTEG_W-1:0] integ_q;
	logic [DEC_W-1:0]   dec_cnt_q;
	logic [INDEX_W-1:0] point_cnt_q;
	logic               capturing_q;
	logic               v_s1;
	tick_t              tick_s1;

	logic                      accept;
	logic                      tick_acc;
	logic                      arm_acc;
	logic [SAMPLE_W-1:0]       reference;
	logic signed [ERR_W-1:0]   err;
	logic signed [INTEG_W:0]   integ_sum;
	logic signed [INTEG_W-1:0] integ_next;
	logic                      cap_point;
	logic                      cap_last;

	assign item.ready = !v_s1 || take;
	assign accept     = item.valid && item.ready;
	assign tick_acc   = accept && !item.action;
	assign arm_acc    = accept && item.action;

	assign reference = (wave_pos_q < WAVE_W'(WAVE_HALF)) ? cfg.ref_high : cfg.ref_low;
	assign err = $signed({1'b0, reference}) - $signed({1'b0, item.adc_sample});
	assign integ_sum = (INTEG_W + 1)'($signed(integ_q)) + (INTEG_W + 1)'(err);

	// clip to the signed 24-bit range
	always_comb begin
		if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
			integ_next = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
				: {1'b0, {(INTEG_W-1){1'b1}}};
		end else begin
			integ_next = integ_sum[INTEG_W-1:0];
		end
	end

	assign cap_point = capturing_q && (dec_cnt_q == DEC_W'(DECIMATION_RATIO - 1));
	assign cap_last  = cap_point && (point_cnt_q == INDEX_W'(CAPTURE_POINTS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_pos_q  <= '0;
			integ_q     <= '0;
			dec_cnt_q   <= '0;
			point_cnt_q <= '0;
			capturing_q <= 1'b0;
			v_s1        <= 1'b0;
		end else begin
			if (tick_acc) begin
				v_s1 <= 1'b1;
			end else if (take) begin
				v_s1 <= 1'b0;
			end
			if (arm_acc) begin
				capturing_q <= 1'b1;
			end
			if (tick_acc) begin
				integ_q <= integ_next;
				wave_pos_q <= (wave_pos_q == WAVE_W'(WAVE_LENGTH - 1)) ? '0
					: wave_pos_q + 1'b1;
				if (capturing_q) begin
					dec_cnt_q <= cap_point ? '0 : dec_cnt_q + 1'b1;
				end
				if (cap_point) begin
					point_cnt_q <= cap_last ? '0 : point_cnt_q + 1'b1;
				end
				if (cap_last) begin
					capturing_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			tick_s1.err   <= err;
			tick_s1.integ <= integ_next;
			tick_s1.cap.valid     <= cap_point;
			tick_s1.cap.measure   <= cap_point ? item.adc_sample : '0;
			tick_s1.cap.reference <= cap_point ? reference : '0;
			tick_s1.cap.index     <= cap_point ? point_cnt_q : '0;
			tick_s1.cap.done      <= cap_last;
		end
	end

	assign tick_valid = v_s1;
	assign tick       = tick_s1;

`ifndef NO_ASSERTIONS
	a_run_ends_on_last_point: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(capturing_q) |-> $past(tick_acc && cap_last))
		else $error("capture run ended without its last point");
	a_point_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		point_cnt_q <= INDEX_W'(CAPTURE_POINTS - 1))
		else $error("point count past end of run");
`endif
endmodule

/* hw/rtl/pdr_pipe.sv */
// pi law and compare scaling: products, duty clamp, compare product, result register
// depends on pdr_pkg and pdr_out_if
module pdr_pipe (
	input  logic           clk,
	input  logic           arst_n,
	input  pdr_pkg::cfg_t  cfg,
	input  logic           tick_valid,
	input  pdr_pkg::tick_t tick,
	output logic           take,
	pdr_out_if.source      result
);
	import pdr_pkg::*;

	logic v_s2, v_s3, v_s4, v_s5;
	logic en2, en3, en4, en5;

	logic signed [PROD_P_W-1:0] prod_p_s2;
	logic signed [PROD_I_W-1:0] prod_i_s2;
	cap_t                       cap_s2;

	logic [DUTY_W-1:0] duty_s3;
	logic [DUTY_W-1:0] dprev_s3;
	cap_t              cap_s3;
	logic [DUTY_W-1:0] duty_held_q;

	logic [CMP_PROD_W-1:0] cmp_prod_s4;
	logic [DUTY_W-1:0]     duty_s4;
	cap_t                  cap_s4;

	logic [PERIOD_W-1:0] compare_s5;
	logic [DUTY_W-1:0]   duty_s5;
	cap_t                cap_s5;

	logic signed [ACC_W-1:0]   acc;
	logic signed [ACC_W-1:0]   acc_rnd;
	logic signed [ACC_W-9:0]   quot;
	logic signed [ACC_W-8:0]   u;
	logic [DUTY_W-1:0]         duty;
	logic [SCALE_W-1:0]        scaled;

	assign en5  = !v_s5 || result.ready;
	assign en4  = !v_s4 || en5;
	assign en3  = !v_s3 || en4;
	assign en2  = !v_s2 || en3;
	assign take = tick_valid && en2;

	// sum of terms, divided by 256 toward zero, offset and clamped
	assign acc     = ACC_W'(prod_p_s2) + ACC_W'(prod_i_s2);
	assign acc_rnd = acc + (acc[ACC_W-1] ? ACC_W'(255) : ACC_W'(0));
	assign quot    = acc_rnd[ACC_W-1:8];
	assign u       = (ACC_W-7)'(quot) + (ACC_W-7)'(DUTY_OFFSET);

	always_comb begin
		priority if (u > (ACC_W-7)'(DUTY_MAX)) begin
			duty = DUTY_W'(DUTY_MAX);
		end else if (u < 0) begin
			duty = '0;
		end else begin
			duty = u[DUTY_W-1:0];
		end
	end

	assign scaled = SCALE_W'(cmp_prod_s4) * SCALE_W'(RECIP_C);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			duty_held_q <= '0;
		end else begin
			if (en2) v_s2 <= tick_valid;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en3 && v_s2) duty_held_q <= duty;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			prod_p_s2 <= PROD_P_W'(cfg.gain_p) * PROD_P_W'(tick.err);
			prod_i_s2 <= PROD_I_W'(cfg.gain_i) * PROD_I_W'(tick.integ);
			cap_s2    <= tick.cap;
		end
		if (en3) begin
			duty_s3  <= duty;
			dprev_s3 <= duty_held_q;
			cap_s3   <= cap_s2;
		end
		if (en4) begin
			cmp_prod_s4 <= CMP_PROD_W'(dprev_s3) * CMP_PROD_W'(cfg.pwm_period);
			duty_s4     <= duty_s3;
			cap_s4      <= cap_s3;
		end
		if (en5) begin
			compare_s5 <= scaled[RECIP_SH +: PERIOD_W];
			duty_s5    <= duty_s4;
			cap_s5     <= cap_s4;
		end
	end

	assign result.valid              = v_s5;
	assign result.pwm_compare        = compare_s5;
	assign result.duty_percent       = duty_s5;
	assign result.capture_valid      = cap_s5.valid;
	assign result.captured_measure   = cap_s5.measure;
	assign result.captured_reference = cap_s5.reference;
	assign result.capture_index      = cap_s5.index;
	assign result.capture_done       = cap_s5.done;

`ifndef NO_ASSERTIONS
	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.duty_percent <= DUTY_W'(DUTY_MAX))
		else $error("duty beat out of range");
	a_done_has_point: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.capture_done |-> result.capture_valid)
		else $error("end of run without a capture point");
	a_held_duty_follows: assert property (@(posedge clk) disable iff (!arst_n)
		en3 && v_s2 |=> duty_held_q == duty_s3)
		else $error("held duty differs from last computed duty");
`endif
endmodule

/* sim/pi_duty_regulator_with_capture_test.sv */
// self-checking testbench for the pi duty regulator with decimated capture
// a scoreboard class predicts each result beat; plain tasks drive ticks, arms and registers
// depends on pdr_pkg, pdr_in_if, pdr_out_if and the pi_duty_regulator_with_capture top level
`timescale 1ns / 100ps

module pi_duty_regulator_with_capture_test;
	import pdr_pkg::*;

	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_ARM  = 1'b1;

	localparam int REG_COUNT      = REG_PWM_PERIOD + 1;
	localparam int RESULT_LATENCY = 5;
	localparam int STALL_LIMIT    = 3000;

	localparam longint SUM_MAX = (longint'(1) << (INTEG_W - 1)) - 1;
	localparam longint SUM_MIN = -(longint'(1) << (INTEG_W - 1));

	typedef struct packed {
		logic [PERIOD_W-1:0] pwm_compare;
		logic [DUTY_W-1:0]   duty_percent;
		logic                capture_valid;
		logic [SAMPLE_W-1:0] captured_measure;
		logic [SAMPLE_W-1:0] captured_reference;
		logic [INDEX_W-1:0]  capture_index;
		logic                capture_done;
	} tick_result_t;

	class pi_duty_predictor;
		logic signed [GAIN_W-1:0]  kp;
		logic signed [GAIN_W-1:0]  ki;
		logic [SAMPLE_W-1:0]       level_hi;
		logic [SAMPLE_W-1:0]       level_lo;
		logic [PERIOD_W-1:0]       period;
		int                        phase_pos;
		logic signed [INTEG_W-1:0] err_sum;
		logic [DUTY_W-1:0]         last_duty;
		int                        tick_div;
		int                        point_no;
		bit                        armed;
		tick_result_t              expected_ticks[$];
		int                        mismatches;
		int                        ticks_seen;
		int                        points_seen;
		int                        runs_done;
		int                        sat_hi_ticks;
		int                        sat_lo_ticks;

		function new();
			kp = '0;
			ki = '0;
			level_hi = REF_HIGH_RST;
			level_lo = REF_LOW_RST;
			period = PWM_PERIOD_RST;
			phase_pos = 0;
			err_sum = '0;
			last_duty = '0;
			tick_div = 0;
			point_no = 0;
			armed = 1'b0;
			mismatches = 0;
			ticks_seen = 0;
			points_seen = 0;
			runs_done = 0;
			sat_hi_ticks = 0;
			sat_lo_ticks = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_GAIN_P:     kp = data;
				REG_GAIN_I:     ki = data;
				REG_REF_HIGH:   level_hi = data[SAMPLE_W-1:0];
				REG_REF_LOW:    level_lo = data[SAMPLE_W-1:0];
				REG_PWM_PERIOD: period = data;
				default: ;
			endcase
		endfunction

		function void note_item(logic act, logic [SAMPLE_W-1:0] smp);
			tick_result_t        r;
			logic [SAMPLE_W-1:0] level;
			longint              err;
			longint              sum;
			longint              acc;
			longint              u;
			if (act == ACT_ARM) begin
				armed = 1'b1;
				return;
			end
			r = '0;
			r.pwm_compare = PERIOD_W'((longint'(last_duty) * longint'(period)) / 100);
			level = (phase_pos < WAVE_HALF) ? level_hi : level_lo;
			err = longint'(level) - longint'(smp);
			sum = longint'(err_sum) + err;
			if (sum > SUM_MAX) begin
				sum = SUM_MAX;
				sat_hi_ticks++;
			end
			if (sum < SUM_MIN) begin
				sum = SUM_MIN;
				sat_lo_ticks++;
			end
			err_sum = INTEG_W'(sum);
			acc = longint'(kp) * err + longint'(ki) * sum;
			u = acc / 256 + DUTY_OFFSET;
			if (u > DUTY_MAX)
				u = DUTY_MAX;
			if (u < 0)
				u = 0;
			last_duty = DUTY_W'(u);
			r.duty_percent = last_duty;
			if (armed) begin
				tick_div++;
				if (tick_div >= DECIMATION_RATIO) begin
					tick_div = 0;
					r.capture_valid = 1'b1;
					r.captured_measure = smp;
					r.captured_reference = level;
					r.capture_index = INDEX_W'(point_no);
					points_seen++;
					point_no++;
					if (point_no >= CAPTURE_POINTS) begin
						point_no = 0;
						armed = 1'b0;
						r.capture_done = 1'b1;
						runs_done++;
					end
				end
			end
			phase_pos = (phase_pos + 1 >= WAVE_LENGTH) ? 0 : phase_pos + 1;
			ticks_seen++;
			expected_ticks.push_back(r);
		endfunction

		function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				mismatches++;
				$display("%0t  %s: expected %0d, actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(tick_result_t got);
			tick_result_t want;
			if (expected_ticks.size() == 0) begin
				mismatches++;
				$display("%0t  result beat with nothing expected: expected none, actual %h",
					$time, got);
				return;
			end
			want = expected_ticks.pop_front();
			cmp_field("pwm_compare", want.pwm_compare, got.pwm_compare);
			cmp_field("duty_percent", want.duty_percent, got.duty_percent);
			cmp_field("capture_valid", want.capture_valid, got.capture_valid);
			cmp_field("captured_measure", want.captured_measure, got.captured_measure);
			cmp_field("captured_reference", want.captured_reference, got.captured_reference);
			cmp_field("capture_index", want.capture_index, got.capture_index);
			cmp_field("capture_done", want.capture_done, got.capture_done);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	pdr_in_if  item_if ();
	pdr_out_if result_if ();

	pi_duty_regulator_with_capture u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_if),
		.result    (result_if),
		.cfg_wr_en (cfg_wr_en),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	pi_duty_predictor model = new();
	int               send_idle_pct = 0;
	int               recv_idle_pct = 0;
	int               stall_cycles = 0;
	tick_result_t     seen_beat;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk) begin
		result_if.ready = ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (result_if.valid && result_if.ready) begin
			seen_beat.pwm_compare = result_if.pwm_compare;
			seen_beat.duty_percent = result_if.duty_percent;
			seen_beat.capture_valid = result_if.capture_valid;
			seen_beat.captured_measure = result_if.captured_measure;
			seen_beat.captured_reference = result_if.captured_reference;
			seen_beat.capture_index = result_if.capture_index;
			seen_beat.capture_done = result_if.capture_done;
			model.check_result(seen_beat);
		end
	end

	always @(posedge clk) begin
		if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t  no beat moved for %0d cycles", $time, STALL_LIMIT);
			$display("TB_ERROR");
			$finish;
		end
	end

	task send_item(input logic act, input logic [SAMPLE_W-1:0] smp);
		while ($urandom_range(99) < send_idle_pct) begin
			item_if.valid = 1'b0;
			@(negedge clk);
		end
		item_if.valid = 1'b1;
		item_if.action = act;
		item_if.adc_sample = smp;
		do
			@(posedge clk);
		while (!item_if.ready);
		model.note_item(act, smp);
		@(negedge clk);
	endtask

	task settle();
		item_if.valid = 1'b0;
		while (model.expected_ticks.size() != 0)
			@(posedge clk);
		repeat (RESULT_LATENCY + 2) @(posedge clk);
		@(negedge clk);
	endtask

	task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en = 1'b1;
		cfg_idx = idx;
		cfg_wdata = data;
		@(posedge clk);
		model.write_reg(idx, data);
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	task apply_setting(input logic [GAIN_W-1:0] gp, input logic [GAIN_W-1:0] gi,
			input logic [SAMPLE_W-1:0] rh, input logic [SAMPLE_W-1:0] rl,
			input logic [PERIOD_W-1:0] pp);
		settle();
		write_reg(REG_GAIN_P, gp);
		write_reg(REG_GAIN_I, gi);
		write_reg(REG_REF_HIGH, {6'($urandom), rh});
		write_reg(REG_REF_LOW, {6'($urandom), rl});
		write_reg(REG_PWM_PERIOD, pp);
		// unmapped indexes must leave every register alone
		for (int i = REG_COUNT; i < 2 ** CFG_IDX_W; i++)
			write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
	endtask

	task random_setting();
		logic [GAIN_W-1:0]   gp;
		logic [GAIN_W-1:0]   gi;
		logic [PERIOD_W-1:0] pp;
		if ($urandom_range(3) == 0) begin
			gp = GAIN_W'($urandom);
			gi = GAIN_W'($urandom);
		end else begin
			gp = GAIN_W'(int'($urandom_range(1024)) - 512);
			gi = GAIN_W'(int'($urandom_range(16)) - 8);
		end
		case ($urandom_range(3))
			0: pp = '0;
			1: pp = '1;
			default: pp = PERIOD_W'($urandom);
		endcase
		apply_setting(gp, gi, SAMPLE_W'($urandom), SAMPLE_W'($urandom), pp);
	endtask

	task send_random(input int count);
		logic [SAMPLE_W-1:0] smp;
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(9))
				0: smp = '0;
				1: smp = '1;
				default: smp = SAMPLE_W'($urandom);
			endcase
			send_item(($urandom_range(99) < 4) ? ACT_ARM : ACT_TICK, smp);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		item_if.valid = 1'b0;
		item_if.action = ACT_TICK;
		item_if.adc_sample = '0;
		result_if.ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_idle_pct = 18;
		recv_idle_pct = 88;

		// register defaults, arm and arm while a run is already going
		send_item(ACT_TICK, '0);
		send_item(ACT_TICK, '1);
		send_item(ACT_ARM, 10'h2AA);
		send_item(ACT_ARM, 10'h155);
		send_item(ACT_TICK, 10'd512);
		send_item(ACT_TICK, '1);
		send_item(ACT_TICK, '0);

		apply_setting(16'sh8000, 16'sh7FFF, '1, '0, '1);
		send_item(ACT_TICK, '0);
		send_item(ACT_TICK, '1);
		send_item(ACT_TICK, 10'h2AA);
		send_item(ACT_TICK, 10'h155);

		apply_setting(16'sh7FFF, 16'sh8000, '0, '1, '0);
		send_item(ACT_TICK, '1);
		send_item(ACT_TICK, '0);
		send_item(ACT_TICK, 10'h3FE);

		apply_setting(16'sd256, 16'sd4, REF_HIGH_RST, REF_LOW_RST, PWM_PERIOD_RST);
		send_item(ACT_TICK, 10'd800);
		send_item(ACT_TICK, 10'd200);

		random_setting();
		send_random(700);

		send_idle_pct = 88;
		recv_idle_pct = 18;
		random_setting();
		send_random(700);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_setting();
		send_random(400);

		random_setting();
		send_random(400);

		settle();
		$display("covered %0d ticks, %0d capture points and %0d complete capture runs",
			model.ticks_seen, model.points_seen, model.runs_done);
		$display("integral clamped high on %0d ticks and low on %0d ticks, %0d mismatches",
			model.sat_hi_ticks, model.sat_lo_ticks, model.mismatches);
		if (model.mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/pdr_pkg.sv
hw/rtl/pdr_in_if.sv
hw/rtl/pdr_out_if.sv
hw/rtl/pdr_cfg.sv
hw/rtl/pdr_front.sv
hw/rtl/pdr_pipe.sv
hw/rtl/pi_duty_regulator_with_capture.sv
sim/pi_duty_regulator_with_capture_test.sv
